/* hdl/rcppm_pkg.sv */
// rcppm_pkg: shared constants, register codes and helpers of the rc ppm frame generator
// no dependencies
`default_nettype none

package rcppm_pkg;

   localparam logic [10:0] NEUTRAL_US    = 11'd1500;
   localparam logic [10:0] CH_MAX_US     = 11'd2000;
   localparam logic [16:0] SYNC_MIN_US   = 17'd3500;
   localparam logic [16:0] PERIOD_MIN_US = 17'd10000;
   localparam logic [16:0] PERIOD_MAX_US = 17'd40000;

   localparam logic CMD_TICK      = 1'b0;
   localparam logic CMD_SET_WIDTH = 1'b1;

   typedef enum logic [1:0] {
      CSR_NEGATIVE_MODE = 2'd0,
      CSR_CHANNEL_COUNT = 2'd1,
      CSR_FRAME_PERIOD  = 2'd2,
      CSR_RUN_ENABLE    = 2'd3
   } csr_index_type;

   // requested period raised to the floor and to the channel minimum, then limited
   function automatic logic [15:0] eff_period(input logic [15:0] period,
                                              input logic [3:0]  count);
      logic [16:0] lo;
      logic [16:0] p;
      lo = 17'(count) * 17'(CH_MAX_US) + SYNC_MIN_US;
      p  = {1'b0, period};
      if (p < PERIOD_MIN_US) p = PERIOD_MIN_US;
      if (p < lo) p = lo;
      if (p > PERIOD_MAX_US) p = PERIOD_MAX_US;
      return p[15:0];
   endfunction

endpackage

`default_nettype wire

/* hdl/rcppm_ram.sv */
// rcppm_ram: generic ram, one write port and two registered read ports
// no dependencies
`default_nettype none

module rcppm_ram #(
   parameter int WIDTH = 11,
   parameter int DEPTH = 12,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic             rd_a_en,
   input  wire logic [AW-1:0]    rd_a_addr,
   output logic      [WIDTH-1:0] rd_a_data,
   input  wire logic             rd_b_en,
   input  wire logic [AW-1:0]    rd_b_addr,
   output logic      [WIDTH-1:0] rd_b_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_a_en) begin
         rd_a_data <= mem_ff[rd_a_addr];
      end
      if (rd_b_en) begin
         rd_b_data <= mem_ff[rd_b_addr];
      end
   end

endmodule

`default_nettype wire

/* hdl/rc_ppm_frame_generator_top.sv */
// rc_ppm_frame_generator_top: rc ppm frame generator, 1 us tick resolution
// depends on rcppm_pkg and rcppm_ram (channel width table)
//
// channel  direction  handshake          payload
// req      in         req_valid/stall    command, channel, pulse_us
// rsp      out        rsp_valid/stall    ppm_out, frame_start, slot_index
// csr      in         csr_valid/ready    csr_index, csr_wdata
//
// one item per clock while neither rsp_stall nor a csr write holds it off; a result passes
// through the table read stage, then the update and result register; the table update is a
// read-modify-write. synchronous reset restores the control and sequence registers; the table
// reads as 1500 through per-entry valid bits. rsp_stall holds the result register, and
// the request side keeps taking items as long as the stage in front of it can drain.
// a csr write is taken only with the read stage empty and holds off requests meanwhile
`default_nettype none

module rc_ppm_frame_generator_top #(
   parameter int MAX_CHANNELS = 12,
   parameter int HEADER_US    = 300
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic        req_command,
   input  wire logic [3:0]  req_channel,
   input  wire logic [11:0] req_pulse_us,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic             rsp_ppm_out,
   output logic             rsp_frame_start,
   output logic [3:0]       rsp_slot_index,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [1:0]  csr_index,
   input  wire logic [15:0] csr_wdata
);

   localparam int AW          = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
   localparam int CCOUNT_MAX  = (MAX_CHANNELS > 15) ? 15 : MAX_CHANNELS;
   localparam int RESET_COUNT = (CCOUNT_MAX < 8) ? CCOUNT_MAX : 8;
   localparam logic [11:0] W_LO = 12'(HEADER_US + 1);
   localparam logic [15:0] HDR  = 16'(HEADER_US);
   localparam logic [15:0] RESET_PERIOD = 16'd20000;

   // configuration
   logic        neg_ff, neg_in;
   logic [3:0]  count_ff, count_in;
   logic [15:0] period_ff, period_in;
   logic [15:0] eff_ff, eff_in;
   logic        run_ff, run_in;

   // sequence state
   logic [14:0] total_ff, total_in;
   logic [3:0]  slot_ff, slot_in;
   logic [15:0] ticks_ff, ticks_in;
   logic        line_ff, line_in;
   logic [10:0] cur_width_ff, cur_width_in;
   logic        pend_ff, pend_in;
   logic        pend_valid_ff, pend_valid_in;
   logic [MAX_CHANNELS-1:0] valid_ff, valid_in;

   // read stage
   logic        s1_valid_ff, s1_valid_in;
   logic        s1_cmd_ff;
   logic [3:0]  s1_channel_ff;
   logic [10:0] s1_width_ff;
   logic        s1_fwd_hit_ff;
   logic [10:0] s1_fwd_data_ff;
   logic        s1_rd_valid_ff;

   // result register
   logic        rsp_valid_ff, rsp_valid_in;
   logic        rsp_ppm_ff;
   logic        rsp_fstart_ff;
   logic [3:0]  rsp_slot_ff;

   logic          accept;
   logic          s1_fire;
   logic          csr_wr;
   logic [10:0]   req_width_clamped;
   logic [3:0]    rd_a_chan;
   logic [AW-1:0] rd_a_addr;
   logic          rd_a_valid;
   logic [AW-1:0] pf_addr;
   logic          pf_valid;
   logic [10:0]   ram_a_q;
   logic [10:0]   ram_b_q;
   logic          wr_en;
   logic [3:0]    wr_chan;
   logic [AW-1:0] wr_addr;
   logic          ch_ok;
   logic [10:0]   old_w;
   logic [15:0]   sync_len;
   logic [15:0]   slot_len;
   logic [15:0]   rest;
   logic [4:0]    slot_inc;
   logic          pf_en;
   logic          fstart;
   logic          active;
   logic [3:0]    c_clamped;

   assign s1_fire   = s1_valid_ff & (~rsp_valid_ff | ~rsp_stall);
   assign req_stall = (s1_valid_ff & ~s1_fire) | csr_valid;
   assign accept    = req_valid & ~req_stall;
   assign csr_ready = ~s1_valid_ff;
   assign csr_wr    = csr_valid & csr_ready;

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_ppm_out     = rsp_ppm_ff;
   assign rsp_frame_start = rsp_fstart_ff;
   assign rsp_slot_index  = rsp_slot_ff;

   assign rd_a_chan  = req_channel - 4'd1;
   assign rd_a_addr  = rd_a_chan[AW-1:0];
   assign rd_a_valid = (32'(rd_a_addr) < MAX_CHANNELS) ? valid_ff[rd_a_addr] : 1'b0;
   assign pf_addr    = slot_ff[AW-1:0];
   assign pf_valid   = (32'(pf_addr) < MAX_CHANNELS) ? valid_ff[pf_addr] : 1'b0;
   assign wr_chan    = s1_channel_ff - 4'd1;
   assign wr_addr    = wr_chan[AW-1:0];

   always_comb begin
      if (req_pulse_us < W_LO) begin
         req_width_clamped = W_LO[10:0];
      end else if (req_pulse_us > 12'(rcppm_pkg::CH_MAX_US)) begin
         req_width_clamped = rcppm_pkg::CH_MAX_US;
      end else begin
         req_width_clamped = req_pulse_us[10:0];
      end
   end

   always_comb begin
      if (csr_wdata[3:0] == 4'd0) begin
         c_clamped = 4'd1;
      end else if (32'(csr_wdata[3:0]) > CCOUNT_MAX) begin
         c_clamped = 4'(CCOUNT_MAX);
      end else begin
         c_clamped = csr_wdata[3:0];
      end
   end

   rcppm_ram #(
      .WIDTH (11),
      .DEPTH (MAX_CHANNELS)
   ) u_width_ram (
      .clock     (clock),
      .wr_en     (wr_en),
      .wr_addr   (wr_addr),
      .wr_data   (s1_width_ff),
      .rd_a_en   (accept),
      .rd_a_addr (rd_a_addr),
      .rd_a_data (ram_a_q),
      .rd_b_en   (pf_en),
      .rd_b_addr (pf_addr),
      .rd_b_data (ram_b_q)
   );

   // item update
   always_comb begin
      ch_ok    = (s1_channel_ff != 4'd0) && (s1_channel_ff <= count_ff);
      old_w    = s1_fwd_hit_ff ? s1_fwd_data_ff
               : (s1_rd_valid_ff ? ram_a_q : rcppm_pkg::NEUTRAL_US);
      wr_en    = s1_fire && (s1_cmd_ff == rcppm_pkg::CMD_SET_WIDTH) && ch_ok;
      sync_len = ({1'b0, total_ff} < eff_ff) ? (eff_ff - {1'b0, total_ff}) : 16'd0;
      slot_len = (slot_ff != 4'd0) ? 16'(cur_width_ff) : sync_len;
      rest     = (slot_len > HDR) ? (slot_len - HDR) : 16'd1;
      slot_inc = {1'b0, slot_ff} + 5'd1;
      active   = (line_ff != neg_ff);

      neg_in        = neg_ff;
      count_in      = count_ff;
      period_in     = period_ff;
      eff_in        = eff_ff;
      run_in        = run_ff;
      total_in      = total_ff;
      slot_in       = slot_ff;
      ticks_in      = ticks_ff;
      line_in       = line_ff;
      pend_in       = 1'b0;
      pend_valid_in = pf_valid;
      pf_en         = 1'b0;
      fstart        = 1'b0;
      cur_width_in  = cur_width_ff;
      valid_in      = valid_ff;

      if (pend_ff) begin
         cur_width_in = pend_valid_ff ? ram_b_q : rcppm_pkg::NEUTRAL_US;
      end

      if (s1_fire) begin
         if (s1_cmd_ff == rcppm_pkg::CMD_SET_WIDTH) begin
            if (ch_ok) begin
               total_in = total_ff - 15'(old_w) + 15'(s1_width_ff);
               for (int i = 0; i < MAX_CHANNELS; i++) begin
                  if (32'(wr_addr) == i) valid_in[i] = 1'b1;
               end
               if (s1_channel_ff == slot_ff) begin
                  cur_width_in = s1_width_ff;
               end
            end
         end else if (run_ff) begin
            if (ticks_ff != 16'd0) begin
               ticks_in = ticks_ff - 16'd1;
            end else if (active) begin
               line_in  = neg_ff;
               ticks_in = rest - 16'd1;
            end else begin
               if (slot_inc > {1'b0, count_ff}) begin
                  slot_in = 4'd0;
                  fstart  = 1'b1;
               end else begin
                  slot_in = slot_inc[3:0];
                  pf_en   = 1'b1;
                  pend_in = 1'b1;
               end
               line_in  = ~neg_ff;
               ticks_in = HDR - 16'd1;
            end
         end
      end

      if (csr_wr) begin
         unique case (rcppm_pkg::csr_index_type'(csr_index))
            rcppm_pkg::CSR_NEGATIVE_MODE: begin
               line_in = line_ff ^ (csr_wdata[0] ^ neg_ff);
               neg_in  = csr_wdata[0];
            end
            rcppm_pkg::CSR_CHANNEL_COUNT: begin
               count_in     = c_clamped;
               eff_in       = rcppm_pkg::eff_period(period_ff, c_clamped);
               valid_in     = '0;
               total_in     = 15'(c_clamped) * 15'(rcppm_pkg::NEUTRAL_US);
               slot_in      = c_clamped;
               ticks_in     = 16'd0;
               line_in      = neg_ff;
               cur_width_in = rcppm_pkg::NEUTRAL_US;
               pend_in      = 1'b0;
            end
            rcppm_pkg::CSR_FRAME_PERIOD: begin
               period_in = csr_wdata;
               eff_in    = rcppm_pkg::eff_period(csr_wdata, count_ff);
            end
            rcppm_pkg::CSR_RUN_ENABLE: begin
               run_in = csr_wdata[0];
            end
         endcase
      end
   end

   always_comb begin
      s1_valid_in  = accept ? 1'b1 : (s1_fire ? 1'b0 : s1_valid_ff);
      rsp_valid_in = s1_fire ? 1'b1 : (rsp_valid_ff & rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         neg_ff        <= 1'b0;
         count_ff      <= 4'(RESET_COUNT);
         period_ff     <= RESET_PERIOD;
         eff_ff        <= rcppm_pkg::eff_period(RESET_PERIOD, 4'(RESET_COUNT));
         run_ff        <= 1'b1;
         total_ff      <= 15'(RESET_COUNT) * 15'(rcppm_pkg::NEUTRAL_US);
         slot_ff       <= 4'(RESET_COUNT);
         ticks_ff      <= 16'd0;
         line_ff       <= 1'b0;
         cur_width_ff  <= rcppm_pkg::NEUTRAL_US;
         pend_ff       <= 1'b0;
         pend_valid_ff <= 1'b0;
         valid_ff      <= '0;
         s1_valid_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         neg_ff        <= neg_in;
         count_ff      <= count_in;
         period_ff     <= period_in;
         eff_ff        <= eff_in;
         run_ff        <= run_in;
         total_ff      <= total_in;
         slot_ff       <= slot_in;
         ticks_ff      <= ticks_in;
         line_ff       <= line_in;
         cur_width_ff  <= cur_width_in;
         pend_ff       <= pend_in;
         pend_valid_ff <= pend_valid_in;
         valid_ff      <= valid_in;
         s1_valid_ff   <= s1_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // read stage payload, with forwarding of a write that lands on the same edge
   always_ff @(posedge clock) begin
      if (accept) begin
         s1_cmd_ff      <= req_command;
         s1_channel_ff  <= req_channel;
         s1_width_ff    <= req_width_clamped;
         s1_fwd_hit_ff  <= wr_en && (req_channel == s1_channel_ff);
         s1_fwd_data_ff <= s1_width_ff;
         s1_rd_valid_ff <= rd_a_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_fire) begin
         rsp_ppm_ff    <= line_in;
         rsp_fstart_ff <= fstart;
         rsp_slot_ff   <= slot_in;
      end
   end

endmodule

`default_nettype wire
